// ===== rtl/core/wbf_pkg.sv =====
// ----------------------------------------------------------------------------
// wbf_pkg
// Shared constants, register indexes and controller/datapath bundles for the
// winnowing bit fingerprint block.
// ----------------------------------------------------------------------------
package wbf_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 32;
  localparam int unsigned FP_BITS_DEF    = 4096;

  localparam int unsigned HASH_W    = 32;
  localparam int unsigned CNT_W     = 24;
  localparam int unsigned WS_W      = 6;
  localparam int unsigned MSB_W     = 13;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STATUS_W  = 2;
  // File tag stored per fingerprint bit
  localparam int unsigned EP_W      = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SET_BITS = 1'd1;

  localparam logic [WS_W-1:0]  WS_RESET  = 6'd12;
  localparam logic [MSB_W-1:0] MSB_RESET = 13'd2048;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd2;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_step;
    logic scan_commit;
    logic take_new;
    logic mod_step;
    logic fp_upd;
    logic load_out;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic rescan;
    logic new_min;
    logic scan_done;
    logic mod_done;
    logic last;
    logic ep_wrap;
    logic clr_done;
  } sts_t;

endpackage

// ===== rtl/core/winnowing_bit_fingerprint.sv =====
// ----------------------------------------------------------------------------
// winnowing_bit_fingerprint
// Winnowing minimum selection over a shred hash stream with a bit fingerprint.
// ----------------------------------------------------------------------------
// One hash is taken at a time. An item that selects nothing goes from decode
// straight to finish; a new minimum adds the bit index step and the
// fingerprint RAM read-modify-write, plus the remainder unit when FP_BITS is
// not a power of two; a window rescan walks the window through one comparator.
// Fingerprint bits carry an 8-bit file tag, so closing a file is free, but
// after reset and after every 255 files a clearing pass over all FP_BITS
// entries runs, during which no hash is accepted.
// Results wait in an output register while the next hash is being worked on.
module winnowing_bit_fingerprint #(
  parameter int unsigned WINDOW_MAX = wbf_pkg::WINDOW_MAX_DEF,
  parameter int unsigned FP_BITS    = wbf_pkg::FP_BITS_DEF,
  localparam int unsigned FP_W  = $clog2(FP_BITS),
  localparam int unsigned SBC_W = $clog2(FP_BITS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wbf_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [wbf_pkg::HASH_W-1:0]   hash_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         selected_o,
  output logic [FP_W-1:0]              bit_index_o,
  output logic                         done_res_o,
  output logic [wbf_pkg::STATUS_W-1:0] status_o,
  output logic [SBC_W-1:0]             set_bit_count_o,
  output logic [wbf_pkg::CNT_W-1:0]    hash_count_o
);
  import wbf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wbf_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .FP_BITS    (FP_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .hash_i          (hash_i),
    .last_i          (last_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .selected_o      (selected_o),
    .bit_index_o     (bit_index_o),
    .done_res_o      (done_res_o),
    .status_o        (status_o),
    .set_bit_count_o (set_bit_count_o),
    .hash_count_o    (hash_count_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("hash accepted while previous one still in work");

  a_no_sel_no_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !selected_o) |-> (bit_index_o == '0))
    else $error("bit index set without a selection");

  a_summary_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |->
      (status_o == ST_OK && set_bit_count_o == '0 && hash_count_o == '0))
    else $error("summary fields set on a non-final result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (status_o == ST_OK || status_o == ST_TOO_FEW || status_o == ST_TOO_MANY))
    else $error("undefined status code");

endmodule

// ===== rtl/core/wbf_ram.sv =====
// ----------------------------------------------------------------------------
// wbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/wbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// wbf_ctrl
// Sequencer: accepts one hash, steps window rescan, bit index reduction and
// fingerprint update, hands the result to the output register.
// ----------------------------------------------------------------------------
module wbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  wbf_pkg::sts_t sts_i,
  output wbf_pkg::cmd_t cmd_o
);
  import wbf_pkg::*;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DEC, S_SCAN, S_MOD, S_RD, S_WR, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.rescan) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end else if (sts_i.new_min) begin
          cmd_o.take_new = 1'b1;
          state_d        = S_MOD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.scan_commit = 1'b1;
          state_d           = S_MOD;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) state_d = S_RD;
        else cmd_o.mod_step = 1'b1;
      end
      S_RD: state_d = S_WR;
      S_WR: begin
        cmd_o.fp_upd = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = (sts_i.last && sts_i.ep_wrap) ? S_CLR : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/wbf_dp.sv =====
// ----------------------------------------------------------------------------
// wbf_dp
// Datapath: hash window, held minimum, serial rescan and bit index reduction,
// tagged fingerprint RAM, per-file counters and the output register.
// ----------------------------------------------------------------------------
module wbf_dp #(
  parameter int unsigned WINDOW_MAX = wbf_pkg::WINDOW_MAX_DEF,
  parameter int unsigned FP_BITS    = wbf_pkg::FP_BITS_DEF,
  localparam int unsigned FP_W  = $clog2(FP_BITS),
  localparam int unsigned SBC_W = $clog2(FP_BITS + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wbf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wbf_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [wbf_pkg::HASH_W-1:0]       hash_i,
  input  logic                             last_i,
  input  wbf_pkg::cmd_t                    cmd_i,
  output wbf_pkg::sts_t                    sts_o,
  output logic                             selected_o,
  output logic [FP_W-1:0]                  bit_index_o,
  output logic                             done_res_o,
  output logic [wbf_pkg::STATUS_W-1:0]     status_o,
  output logic [SBC_W-1:0]                 set_bit_count_o,
  output logic [wbf_pkg::CNT_W-1:0]        hash_count_o
);
  import wbf_pkg::*;

  localparam int unsigned WIDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned WSE_W  = $clog2(WINDOW_MAX + 1);
  localparam bit          POW2   = ((FP_BITS & (FP_BITS - 1)) == 0);
  localparam int unsigned CMP_W  = (SBC_W > MSB_W) ? SBC_W : MSB_W;
  localparam int unsigned MB_W   = 2;
  // Reciprocal of FP_BITS; the quotient estimate is low by at most one
  localparam logic [HASH_W-1:0] RECIP =
    HASH_W'((64'd1 << HASH_W) / 64'(FP_BITS));
  // Remainder steps, counted down
  localparam logic [MB_W-1:0] MS_QUO = 2'd3;
  localparam logic [MB_W-1:0] MS_SUB = 2'd2;
  localparam logic [MB_W-1:0] MS_FIX = 2'd1;

  logic [WS_W-1:0]   ws_q;
  logic [MSB_W-1:0]  msb_q;
  logic [HASH_W-1:0] win_q [WINDOW_MAX];
  logic [HASH_W-1:0] hash_q, curmin_q, cand_q;
  logic              last_q, minv_q, sel_q;
  logic [CNT_W-1:0]  items_q, minpos_q, msel_q;
  logic [WIDX_W-1:0] k_q, age_q;
  logic [FP_W-1:0]   rem_q;
  logic [MB_W-1:0]   mbit_q;
  logic [HASH_W-1:0] quo_q, part_q;
  logic [SBC_W-1:0]  bits_q;
  logic [EP_W-1:0]   epoch_q, rdata;
  logic [FP_W-1:0]   clr_q;

  logic [WSE_W-1:0]    ws_eff;
  logic [CNT_W-1:0]    ws_cnt;
  logic                full;
  logic [WIDX_W-1:0]   idx0, kn;
  logic [MB_W-1:0]     mb1;
  logic [2*HASH_W-1:0] quo_prod;
  logic [HASH_W-1:0]   quo_mul;
  logic [FP_W-1:0]     bit_idx;
  logic                fp_hit;
  logic                ram_we;
  logic [FP_W-1:0]     ram_waddr;
  logic [EP_W-1:0]     ram_wdata;

  // Clamp the window size to 1..WINDOW_MAX
  always_comb begin
    if (ws_q == '0) ws_eff = WSE_W'(1);
    else if (32'(ws_q) > WINDOW_MAX) ws_eff = WSE_W'(WINDOW_MAX);
    else ws_eff = WSE_W'(ws_q);
  end

  assign ws_cnt   = CNT_W'(ws_eff);
  assign full     = (items_q >= ws_cnt);
  assign idx0     = WIDX_W'(ws_eff - WSE_W'(1));
  assign kn       = k_q - WIDX_W'(1);
  assign mb1      = mbit_q - MB_W'(1);
  assign quo_prod = (2*HASH_W)'(curmin_q) * (2*HASH_W)'(RECIP);
  assign quo_mul  = HASH_W'((2*HASH_W)'(quo_q) * (2*HASH_W)'(FP_BITS));
  assign bit_idx  = POW2 ? curmin_q[FP_W-1:0] : rem_q;
  assign fp_hit   = (rdata == epoch_q);

  always_comb begin
    sts_o           = '0;
    sts_o.rescan    = full && (!minv_q || minpos_q >= ws_cnt);
    sts_o.new_min   = full && minv_q && (minpos_q < ws_cnt) && (hash_q <= curmin_q);
    sts_o.scan_done = (k_q == '0);
    sts_o.mod_done  = POW2 || (mbit_q == '0);
    sts_o.last      = last_q;
    sts_o.ep_wrap   = (epoch_q == '1);
    sts_o.clr_done  = (32'(clr_q) == FP_BITS - 1);
  end

  assign ram_we    = cmd_i.clr_step || (cmd_i.fp_upd && !fp_hit);
  assign ram_waddr = cmd_i.clr_step ? clr_q : bit_idx;
  assign ram_wdata = cmd_i.clr_step ? '0 : epoch_q;

  wbf_ram #(
    .WIDTH (EP_W),
    .DEPTH (FP_BITS)
  ) u_fp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (bit_idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q     <= WS_RESET;
      msb_q    <= MSB_RESET;
      for (int i = 0; i < WINDOW_MAX; i++) win_q[i] <= '0;
      items_q  <= '0;
      minpos_q <= '0;
      minv_q   <= 1'b0;
      curmin_q <= '0;
      msel_q   <= '0;
      bits_q   <= '0;
      sel_q    <= 1'b0;
      last_q   <= 1'b0;
      k_q      <= '0;
      mbit_q   <= '0;
      epoch_q  <= EP_W'(1);
      clr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_SIZE:  ws_q  <= cfg_data_i[WS_W-1:0];
          REG_MAX_SET_BITS: msb_q <= cfg_data_i[MSB_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.accept) begin
        hash_q <= hash_i;
        last_q <= last_i;
        sel_q  <= 1'b0;
        win_q[0] <= hash_i;
        for (int i = 1; i < WINDOW_MAX; i++) win_q[i] <= win_q[i-1];
        if (items_q != CNT_MAX) items_q <= items_q + CNT_W'(1);
        if (minv_q && minpos_q != CNT_MAX) minpos_q <= minpos_q + CNT_W'(1);
      end

      // Rescan from the oldest entry toward the newest; ties take the newer
      if (cmd_i.scan_init) begin
        k_q    <= idx0;
        cand_q <= win_q[idx0];
        age_q  <= idx0;
      end
      if (cmd_i.scan_step) begin
        k_q <= kn;
        if (win_q[kn] <= cand_q) begin
          cand_q <= win_q[kn];
          age_q  <= kn;
        end
      end
      if (cmd_i.scan_commit) begin
        curmin_q <= cand_q;
        minpos_q <= CNT_W'(age_q);
        minv_q   <= 1'b1;
        sel_q    <= 1'b1;
      end
      if (cmd_i.take_new) begin
        curmin_q <= hash_q;
        minpos_q <= '0;
        sel_q    <= 1'b1;
      end
      if (cmd_i.scan_commit || cmd_i.take_new) begin
        rem_q  <= '0;
        mbit_q <= MS_QUO;
      end

      // Estimate the quotient, subtract its multiple, then correct once
      if (cmd_i.mod_step) begin
        mbit_q <= mb1;
        case (mbit_q)
          MS_QUO: quo_q  <= quo_prod[2*HASH_W-1:HASH_W];
          MS_SUB: part_q <= curmin_q - quo_mul;
          MS_FIX: begin
            if (32'(part_q) >= FP_BITS) rem_q <= FP_W'(part_q - HASH_W'(FP_BITS));
            else rem_q <= FP_W'(part_q);
          end
          default: ;
        endcase
      end

      if (cmd_i.fp_upd) begin
        if (!fp_hit) bits_q <= bits_q + SBC_W'(1);
        if (msel_q != CNT_MAX) msel_q <= msel_q + CNT_W'(1);
      end

      if (cmd_i.load_out && last_q) begin
        bits_q   <= '0;
        msel_q   <= '0;
        items_q  <= '0;
        curmin_q <= '0;
        minpos_q <= '0;
        minv_q   <= 1'b0;
        epoch_q  <= (epoch_q == '1) ? EP_W'(1) : epoch_q + EP_W'(1);
      end

      if (cmd_i.clr_step) begin
        clr_q <= (32'(clr_q) == FP_BITS - 1) ? '0 : clr_q + FP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      selected_o      <= sel_q;
      bit_index_o     <= sel_q ? bit_idx : '0;
      done_res_o      <= last_q;
      status_o        <= ST_OK;
      set_bit_count_o <= '0;
      hash_count_o    <= '0;
      if (last_q) begin
        if (items_q < ws_cnt) status_o <= ST_TOO_FEW;
        else if (CMP_W'(bits_q) > CMP_W'(msb_q)) status_o <= ST_TOO_MANY;
        set_bit_count_o <= bits_q;
        hash_count_o    <= msel_q;
      end
    end
  end

endmodule
